// ----- design/spa_pkg.sv -----
// shared types, codes and helpers of the sparse polynomial adder
package spa_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int EXP_WIDTH_DEF = 16;
    localparam int COEFF_W       = 32;
    localparam int EXP_FIELD_W   = 16;

    typedef enum logic [1:0] {
        ACT_INS_FIRST  = 2'd0,
        ACT_INS_SECOND = 2'd1,
        ACT_SUM        = 2'd2,
        ACT_CLEAR      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef struct packed {
        action_t                   action;
        logic signed [COEFF_W-1:0] coefficient;
        logic [EXP_FIELD_W-1:0]    exponent;
    } in_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] term_coeff;
        logic [EXP_FIELD_W-1:0]    term_exponent;
        logic                      last;
        status_t                   status;
    } out_t;

    // requests from the sequencer to one term table
    typedef struct packed {
        logic ins;
        logic clr;
        logic scan_load;
        logic scan_pop;
    } tbl_ctrl_t;

    // what one insert would do to a table
    typedef struct packed {
        logic match;
        logic full;
        logic sat;
    } tbl_stat_t;

    // per-cell commands inside a table
    typedef struct packed {
        logic ins_new;
        logic ins_add;
        logic scan_load;
        logic scan_pop;
    } cell_ctrl_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] sum;
        logic                      sat;
    } sat_sum_t;

    function automatic sat_sum_t sat_add(input logic signed [COEFF_W-1:0] a,
                                         input logic signed [COEFF_W-1:0] b);
        logic [COEFF_W:0] s;
        sat_sum_t         r;
        s = {a[COEFF_W-1], a} + {b[COEFF_W-1], b};
        r.sat = (s[COEFF_W] != s[COEFF_W-1]);
        if (r.sat) begin
            r.sum = s[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
        end else begin
            r.sum = s[COEFF_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/spa_cell.sv -----
// one term slot of a table: stored term, insert compare/add and scan copy
module spa_cell #(
    parameter int EXP_WIDTH = spa_pkg::EXP_WIDTH_DEF
) (
    input  logic                               aclk,
    input  spa_pkg::cell_ctrl_t                ctrl,
    input  logic                               occ,
    input  logic signed [spa_pkg::COEFF_W-1:0] new_coeff,
    input  logic [EXP_WIDTH-1:0]               new_exp,
    input  logic                               left_gt,
    input  logic signed [spa_pkg::COEFF_W-1:0] left_coeff,
    input  logic [EXP_WIDTH-1:0]               left_exp,
    input  logic signed [spa_pkg::COEFF_W-1:0] right_scan_coeff,
    input  logic [EXP_WIDTH-1:0]               right_scan_exp,
    output logic                               gt,
    output logic                               eq,
    output logic                               sat,
    output logic signed [spa_pkg::COEFF_W-1:0] coeff,
    output logic [EXP_WIDTH-1:0]               exp,
    output logic signed [spa_pkg::COEFF_W-1:0] scan_coeff,
    output logic [EXP_WIDTH-1:0]               scan_exp
);
    import spa_pkg::*;

    logic signed [COEFF_W-1:0] coeff_reg, coeff_next;
    logic [EXP_WIDTH-1:0]      exp_reg, exp_next;
    logic signed [COEFF_W-1:0] scan_coeff_reg, scan_coeff_next;
    logic [EXP_WIDTH-1:0]      scan_exp_reg, scan_exp_next;
    sat_sum_t                  add;

    assign gt  = occ && (exp_reg > new_exp);
    assign eq  = occ && (exp_reg == new_exp);
    assign add = sat_add(coeff_reg, new_coeff);
    assign sat = add.sat;

    always_comb begin
        coeff_next = coeff_reg;
        exp_next   = exp_reg;
        if (ctrl.ins_add && eq) begin
            coeff_next = add.sum;
        end else if (ctrl.ins_new && !gt) begin
            // first slot not above the new exponent takes it, the rest move down
            if (left_gt) begin
                coeff_next = new_coeff;
                exp_next   = new_exp;
            end else begin
                coeff_next = left_coeff;
                exp_next   = left_exp;
            end
        end
    end

    always_comb begin
        scan_coeff_next = scan_coeff_reg;
        scan_exp_next   = scan_exp_reg;
        if (ctrl.scan_load) begin
            scan_coeff_next = coeff_reg;
            scan_exp_next   = exp_reg;
        end else if (ctrl.scan_pop) begin
            scan_coeff_next = right_scan_coeff;
            scan_exp_next   = right_scan_exp;
        end
    end

    always_ff @(posedge aclk) begin
        coeff_reg      <= coeff_next;
        exp_reg        <= exp_next;
        scan_coeff_reg <= scan_coeff_next;
        scan_exp_reg   <= scan_exp_next;
    end

    assign coeff      = coeff_reg;
    assign exp        = exp_reg;
    assign scan_coeff = scan_coeff_reg;
    assign scan_exp   = scan_exp_reg;

endmodule

// ----- design/spa_table.sv -----
// sorted term table: row of cells plus fill count
module spa_table #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    parameter int EXP_WIDTH = spa_pkg::EXP_WIDTH_DEF,
    parameter int CNT_W     = $clog2(MAX_TERMS + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  spa_pkg::tbl_ctrl_t                 ctrl,
    input  logic signed [spa_pkg::COEFF_W-1:0] new_coeff,
    input  logic [EXP_WIDTH-1:0]               new_exp,
    output spa_pkg::tbl_stat_t                 stat,
    output logic [CNT_W-1:0]                   count,
    output logic signed [spa_pkg::COEFF_W-1:0] head_coeff,
    output logic [EXP_WIDTH-1:0]               head_exp
);
    import spa_pkg::*;

    logic [CNT_W-1:0]          count_reg;
    cell_ctrl_t                cctl;
    logic [MAX_TERMS-1:0]      occ, gt, eq, sat;
    logic signed [COEFF_W-1:0] coeff_w [MAX_TERMS];
    logic [EXP_WIDTH-1:0]      exp_w [MAX_TERMS];
    logic signed [COEFF_W-1:0] scan_c [MAX_TERMS];
    logic [EXP_WIDTH-1:0]      scan_e [MAX_TERMS];

    assign stat.match = |eq;
    assign stat.sat   = |(eq & sat);
    assign stat.full  = !stat.match && (count_reg == CNT_W'(MAX_TERMS));

    assign cctl.ins_new   = ctrl.ins && !stat.match && !stat.full;
    assign cctl.ins_add   = ctrl.ins && stat.match;
    assign cctl.scan_load = ctrl.scan_load;
    assign cctl.scan_pop  = ctrl.scan_pop;

    for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
        localparam int PRV = (k + MAX_TERMS - 1) % MAX_TERMS;
        localparam int NXT = (k + 1) % MAX_TERMS;
        logic left_gt;

        assign occ[k]  = CNT_W'(k) < count_reg;
        // the head slot has nothing above it
        assign left_gt = (k == 0) ? 1'b1 : gt[PRV];

        spa_cell #(
            .EXP_WIDTH(EXP_WIDTH)
        ) u_cell (
            .aclk             (aclk),
            .ctrl             (cctl),
            .occ              (occ[k]),
            .new_coeff        (new_coeff),
            .new_exp          (new_exp),
            .left_gt          (left_gt),
            .left_coeff       (coeff_w[PRV]),
            .left_exp         (exp_w[PRV]),
            .right_scan_coeff (scan_c[NXT]),
            .right_scan_exp   (scan_e[NXT]),
            .gt               (gt[k]),
            .eq               (eq[k]),
            .sat              (sat[k]),
            .coeff            (coeff_w[k]),
            .exp              (exp_w[k]),
            .scan_coeff       (scan_c[k]),
            .scan_exp         (scan_e[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.clr) begin
            count_reg <= '0;
        end else if (cctl.ins_new) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign count      = count_reg;
    assign head_coeff = scan_c[0];
    assign head_exp   = scan_e[0];

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TERMS))
        else $error("term count above table size");

    a_full_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.ins && stat.full && !ctrl.clr) |=> (count_reg == $past(count_reg)))
        else $error("insert into full table changed the count");

endmodule

// ----- design/sparse_polynomial_adder_unit.sv -----
// top level of the sparse polynomial adder: sequencer, merge and result register
//
// usage
//   s_ channel: one transfer per request (insert first, insert second, sum, clear)
//   m_ channel: result transfers; inserts and clears give one result, a sum gives
//   one result per nonzero merged term (highest exponent first, last on the final
//   one) or a single result with status empty
//   an insert result is registered in the exec state, the sorted insert across the
//   whole row of cells in the same cycle; both wait while the result register is full
//   a sum loads both scan chains, then does merge steps (at most the sum of both
//   term counts) and a closing step, each held while the result register is full
//   the merge walks both scan chains, which shift one slot toward the head per pop
//   s_ready is high only while no request is in work; the next request can be
//   taken while the previous result still waits in the output register
//   a stalled receiver holds the result register and freezes the merge
//   reset clears both term counts, the output valid and the sequencer
module sparse_polynomial_adder_unit #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF,
    parameter int EXP_WIDTH = spa_pkg::EXP_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  spa_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output spa_pkg::out_t m_data
);
    import spa_pkg::*;

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MERGE
    } state_t;

    state_t            state_reg;
    in_t               in_reg;
    out_t              out_reg;
    logic              out_valid_reg;
    out_t              pend_reg;
    logic              pend_valid_reg;
    logic [CNT_W-1:0]  rem1_reg, rem2_reg;

    // request exponent cut to the stored width
    logic [EXP_WIDTH+EXP_FIELD_W-1:0] exp_ext;
    logic [EXP_WIDTH-1:0]             new_exp;

    tbl_ctrl_t                 tctl1, tctl2;
    tbl_stat_t                 tstat1, tstat2, tstat_sel;
    logic [CNT_W-1:0]          cnt1, cnt2;
    logic signed [COEFF_W-1:0] h1_coeff, h2_coeff;
    logic [EXP_WIDTH-1:0]      h1_exp, h2_exp;

    logic                      adv;
    logic                      have1, have2;
    logic                      pop1, pop2;
    logic                      cand_valid;
    out_t                      cand;
    sat_sum_t                  hsum;
    logic [EXP_WIDTH-1:0]      cand_exp;
    logic [EXP_WIDTH+EXP_FIELD_W-1:0] cand_exp_ext;
    status_t                   ins_status;
    out_t                      ack;

    assign exp_ext = {{EXP_WIDTH{1'b0}}, in_reg.exponent};
    assign new_exp = exp_ext[EXP_WIDTH-1:0];

    spa_table #(
        .MAX_TERMS (MAX_TERMS),
        .EXP_WIDTH (EXP_WIDTH),
        .CNT_W     (CNT_W)
    ) u_first (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (tctl1),
        .new_coeff  (in_reg.coefficient),
        .new_exp    (new_exp),
        .stat       (tstat1),
        .count      (cnt1),
        .head_coeff (h1_coeff),
        .head_exp   (h1_exp)
    );

    spa_table #(
        .MAX_TERMS (MAX_TERMS),
        .EXP_WIDTH (EXP_WIDTH),
        .CNT_W     (CNT_W)
    ) u_second (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (tctl2),
        .new_coeff  (in_reg.coefficient),
        .new_exp    (new_exp),
        .stat       (tstat2),
        .count      (cnt2),
        .head_coeff (h2_coeff),
        .head_exp   (h2_exp)
    );

    // result register free or being emptied this cycle
    assign adv = !out_valid_reg || m_ready;

    // merge step: pick from the scan heads
    assign have1 = (rem1_reg != '0);
    assign have2 = (rem2_reg != '0);
    assign hsum  = sat_add(h1_coeff, h2_coeff);

    always_comb begin
        pop1          = 1'b0;
        pop2          = 1'b0;
        cand_valid    = have1 || have2;
        cand_exp      = h1_exp;
        cand.term_coeff = h1_coeff;
        cand.last     = 1'b0;
        cand.status   = ST_OK;
        priority if (have1 && have2) begin
            priority if (h1_exp > h2_exp) begin
                pop1 = 1'b1;
            end else if (h1_exp < h2_exp) begin
                pop2            = 1'b1;
                cand_exp        = h2_exp;
                cand.term_coeff = h2_coeff;
            end else begin
                // equal exponents combine
                pop1            = 1'b1;
                pop2            = 1'b1;
                cand.term_coeff = hsum.sum;
                cand.status     = hsum.sat ? ST_SAT : ST_OK;
            end
        end else if (have1) begin
            pop1 = 1'b1;
        end else begin
            pop2            = have2;
            cand_exp        = h2_exp;
            cand.term_coeff = h2_coeff;
        end
        cand_exp_ext       = {{EXP_FIELD_W{1'b0}}, cand_exp};
        cand.term_exponent = cand_exp_ext[EXP_FIELD_W-1:0];
    end

    // insert acknowledge
    assign tstat_sel = (in_reg.action == ACT_INS_SECOND) ? tstat2 : tstat1;

    always_comb begin
        priority if (tstat_sel.full) begin
            ins_status = ST_FULL;
        end else if (tstat_sel.match && tstat_sel.sat) begin
            ins_status = ST_SAT;
        end else begin
            ins_status = ST_OK;
        end
    end

    always_comb begin
        ack.term_coeff    = '0;
        ack.term_exponent = '0;
        ack.last          = 1'b1;
        ack.status        = ST_OK;
        if (in_reg.action == ACT_INS_FIRST || in_reg.action == ACT_INS_SECOND) begin
            ack.status = ins_status;
        end
    end

    // table requests
    always_comb begin
        tctl1 = '0;
        tctl2 = '0;
        unique case (state_reg)
            S_EXEC: begin
                unique case (in_reg.action)
                    ACT_INS_FIRST:  tctl1.ins = adv;
                    ACT_INS_SECOND: tctl2.ins = adv;
                    ACT_SUM: begin
                        tctl1.scan_load = 1'b1;
                        tctl2.scan_load = 1'b1;
                    end
                    ACT_CLEAR: begin
                        tctl1.clr = adv;
                        tctl2.clr = adv;
                    end
                    default: ;
                endcase
            end
            S_MERGE: begin
                tctl1.scan_pop = adv && pop1;
                tctl2.scan_pop = adv && pop2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            rem1_reg       <= '0;
            rem2_reg       <= '0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (in_reg.action == ACT_SUM) begin
                        rem1_reg       <= cnt1;
                        rem2_reg       <= cnt2;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_MERGE;
                    end else if (adv) begin
                        out_reg       <= ack;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_MERGE: begin
                    if (adv) begin
                        if (cand_valid) begin
                            if (pop1) begin
                                rem1_reg <= rem1_reg - 1'b1;
                            end
                            if (pop2) begin
                                rem2_reg <= rem2_reg - 1'b1;
                            end
                            // zero terms are dropped; a held term goes out once a
                            // later nonzero term proves it is not the last
                            if (cand.term_coeff != '0) begin
                                if (pend_valid_reg) begin
                                    out_reg       <= pend_reg;
                                    out_valid_reg <= 1'b1;
                                end
                                pend_reg       <= cand;
                                pend_valid_reg <= 1'b1;
                            end
                        end else begin
                            if (pend_valid_reg) begin
                                out_reg <= '{term_coeff:    pend_reg.term_coeff,
                                             term_exponent: pend_reg.term_exponent,
                                             last:          1'b1,
                                             status:        pend_reg.status};
                            end else begin
                                out_reg.term_coeff    <= '0;
                                out_reg.term_exponent <= '0;
                                out_reg.last          <= 1'b1;
                                out_reg.status        <= ST_EMPTY;
                            end
                            out_valid_reg  <= 1'b1;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_idle_no_held_term: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("held sum term while accepting a new request");

    a_held_term_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (pend_reg.term_coeff != '0))
        else $error("zero term held for output");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == ST_EMPTY) |-> (m_data.last && m_data.term_coeff == '0))
        else $error("empty-sum result not marked last");

    a_scan_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE) |-> (rem1_reg <= cnt1 && rem2_reg <= cnt2))
        else $error("merge walked past a table's terms");

endmodule
